[rtl/pli_pkg.sv]
// Shared types and constants for the piecewise linear interpolator.
`timescale 1ns / 1ps

package pli_pkg;

	localparam int unsigned VAL_W    = 32;
	localparam int unsigned PROD_W   = 2 * VAL_W;
	localparam int unsigned IDX_W    = 6;
	localparam int unsigned CNT_W    = 7;
	localparam int unsigned REGION_W = 2;
	localparam int unsigned S_DATA_W = 104;
	localparam int unsigned M_DATA_W = 32;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [REGION_W-1:0] REGION_INTERIOR = 2'd0;
	localparam logic [REGION_W-1:0] REGION_BELOW    = 2'd1;
	localparam logic [REGION_W-1:0] REGION_ABOVE    = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LO,
		ST_HI,
		ST_SCAN,
		ST_DIFF,
		ST_MUL,
		ST_DSTART,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} state_t;

endpackage

[rtl/pli_table.sv]
// Breakpoint memory: one write port, one registered read port, entries hold {f, x}.
`timescale 1ns / 1ps

module pli_table
	import pli_pkg::*;
#(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  logic [PROD_W-1:0]   wr_data,
	input  logic [AW-1:0]       rd_addr,
	output logic [PROD_W-1:0]   rd_data
);

	logic [PROD_W-1:0] mem [DEPTH];
	logic [PROD_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/pli_div.sv]
// Restoring divider, one quotient bit per cycle, 64 / 32 with a 32-bit quotient.
`timescale 1ns / 1ps

module pli_div
	import pli_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [PROD_W-1:0]   dividend,
	input  logic [VAL_W-1:0]    divisor,
	output logic                done,
	output logic [VAL_W-1:0]    quotient
);

	localparam int unsigned STEP_W = $clog2(VAL_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [VAL_W-1:0]  rem_q;
	logic [VAL_W-1:0]  sh_q;

	logic [VAL_W:0]    trial;
	logic [VAL_W+1:0]  diff;
	logic              ge;

	// high half of the dividend is below the divisor, so the remainder fits 32 bits
	assign trial = {rem_q, sh_q[VAL_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, divisor};
	assign ge    = ~diff[VAL_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(VAL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[PROD_W-1:VAL_W];
			sh_q  <= dividend[VAL_W-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
			sh_q  <= {sh_q[VAL_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = sh_q;

endmodule

[rtl/piecewise_linear_interpolator.sv]
// Piecewise linear interpolation over a breakpoint table, signed Q16.16.
// Load beats are written to the table on accept. A query clamped below is decided in ST_LO,
// one clamped above in ST_HI. An interior query stopping at entry i goes through a scan of one
// table read per cycle, one multiply, then the serial divider. One query at a time.
// Async reset (arst_n low) clears control and sets point_count to 2; table is not cleared.
`timescale 1ns / 1ps

module piecewise_linear_interpolator
	import pli_pkg::*;
#(
	parameter int unsigned MAX_POINTS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CNT_W-1:0]      cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// entry_index[5:0], entry_x[37:6], entry_f[69:38], query_x[101:70], zero pad
	input  logic [S_DATA_W-1:0]   s_tdata,
	// cmd[0]
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// result_value[31:0]
	output logic [M_DATA_W-1:0]   m_tdata,
	// region[1:0]
	output logic [REGION_W-1:0]   m_tuser
);

	localparam int unsigned AW = $clog2(MAX_POINTS);

	state_t state_q, state_d;

	logic [CNT_W-1:0]        point_count_q;
	logic [AW-1:0]           last_d, last_q;
	logic [AW-1:0]           idx_q;
	logic [AW-1:0]           rd_addr;
	logic [PROD_W-1:0]       rd_data;
	logic signed [VAL_W-1:0] rd_x, rd_f;

	logic signed [VAL_W-1:0] q_q;
	logic signed [VAL_W-1:0] prev_x_q, prev_f_q, cur_x_q, cur_f_q;
	logic [VAL_W-1:0]        dq_q, dx_q, mag_q;
	logic                    neg_q;
	logic [PROD_W-1:0]       prod_q;
	logic signed [VAL_W-1:0] res_q;
	logic [REGION_W-1:0]     region_q;

	logic                    out_valid_q;
	logic [VAL_W-1:0]        out_data_q;
	logic [REGION_W-1:0]     out_region_q;

	logic                    in_accept;
	logic                    load_wr;
	logic [IDX_W-1:0]        in_idx;
	logic signed [VAL_W-1:0] in_x, in_f, in_q;

	logic                    lo_hit, hi_hit, scan_hit;
	logic                    div_start, div_done;
	logic [VAL_W-1:0]        quo;
	logic                    out_load;

	logic [VAL_W:0]          dq_w, dx_w, df_w, negdf_w;
	logic [VAL_W+1:0]        sum_w;

	assign in_idx = s_tdata[IDX_W-1:0];
	assign in_x   = s_tdata[IDX_W+VAL_W-1:IDX_W];
	assign in_f   = s_tdata[IDX_W+2*VAL_W-1:IDX_W+VAL_W];
	assign in_q   = s_tdata[IDX_W+3*VAL_W-1:IDX_W+2*VAL_W];

	assign s_tready  = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign load_wr   = in_accept && (s_tuser == CMD_LOAD) && (32'(in_idx) < MAX_POINTS);

	// last entry in use: point_count clamped to 1..MAX_POINTS, minus one
	always_comb begin
		if (point_count_q == '0) begin
			last_d = '0;
		end else if (32'(point_count_q) > MAX_POINTS) begin
			last_d = AW'(MAX_POINTS - 1);
		end else begin
			last_d = AW'(point_count_q - CNT_W'(1));
		end
	end

	pli_table #(
		.DEPTH (MAX_POINTS),
		.AW    (AW)
	) u_table (
		.clk     (clk),
		.wr_en   (load_wr),
		.wr_addr (AW'(in_idx)),
		.wr_data ({in_f, in_x}),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_x = rd_data[VAL_W-1:0];
	assign rd_f = rd_data[PROD_W-1:VAL_W];

	assign lo_hit   = (q_q <= rd_x);
	assign hi_hit   = (q_q >= rd_x);
	assign scan_hit = (idx_q == last_q) || (rd_x >= q_q);

	pli_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (dx_q),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		rd_addr   = '0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept && s_tuser == CMD_QUERY) begin
					state_d = ST_LO;
				end
			end
			ST_LO: begin
				if (lo_hit) begin
					state_d = ST_OUT;
				end else begin
					rd_addr = last_q;
					state_d = ST_HI;
				end
			end
			ST_HI: begin
				if (hi_hit) begin
					state_d = ST_OUT;
				end else begin
					rd_addr = AW'(1);
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_hit) begin
					state_d = ST_DIFF;
				end else begin
					rd_addr = idx_q + AW'(1);
				end
			end
			ST_DIFF:   state_d = ST_MUL;
			ST_MUL:    state_d = ST_DSTART;
			ST_DSTART: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN:    state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// interval arithmetic; the scan guarantees prev_x < q <= cur_x
	assign dq_w    = {q_q[VAL_W-1], q_q} - {prev_x_q[VAL_W-1], prev_x_q};
	assign dx_w    = {cur_x_q[VAL_W-1], cur_x_q} - {prev_x_q[VAL_W-1], prev_x_q};
	assign df_w    = {cur_f_q[VAL_W-1], cur_f_q} - {prev_f_q[VAL_W-1], prev_f_q};
	assign negdf_w = (VAL_W+1)'(0) - df_w;
	assign sum_w   = neg_q ? {{2{prev_f_q[VAL_W-1]}}, prev_f_q} - {2'b00, quo}
	                       : {{2{prev_f_q[VAL_W-1]}}, prev_f_q} + {2'b00, quo};

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					q_q    <= in_q;
					last_q <= last_d;
				end
			end
			ST_LO: begin
				prev_x_q <= rd_x;
				prev_f_q <= rd_f;
				res_q    <= rd_f;
				region_q <= REGION_BELOW;
			end
			ST_HI: begin
				res_q    <= rd_f;
				region_q <= REGION_ABOVE;
				idx_q    <= AW'(1);
			end
			ST_SCAN: begin
				if (scan_hit) begin
					cur_x_q <= rd_x;
					cur_f_q <= rd_f;
				end else begin
					prev_x_q <= rd_x;
					prev_f_q <= rd_f;
					idx_q    <= idx_q + AW'(1);
				end
			end
			ST_DIFF: begin
				dq_q  <= dq_w[VAL_W-1:0];
				dx_q  <= dx_w[VAL_W-1:0];
				neg_q <= df_w[VAL_W];
				mag_q <= df_w[VAL_W] ? negdf_w[VAL_W-1:0] : df_w[VAL_W-1:0];
			end
			ST_MUL: begin
				prod_q <= mag_q * dq_q;
			end
			ST_FIN: begin
				region_q <= REGION_INTERIOR;
				if (sum_w[VAL_W+1:VAL_W-1] == 3'b000 || sum_w[VAL_W+1:VAL_W-1] == 3'b111) begin
					res_q <= sum_w[VAL_W-1:0];
				end else if (sum_w[VAL_W+1]) begin
					res_q <= {1'b1, {(VAL_W-1){1'b0}}};
				end else begin
					res_q <= {1'b0, {(VAL_W-1){1'b1}}};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= CNT_W'(2);
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				point_count_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q   <= res_q;
			out_region_q <= region_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_region_q;

endmodule
